### rtl/mdiomm_pkg.sv
// ----------------------------------------------------------------------------
// mdiomm_pkg
// Shared types and constants for the clause 22 mdio management master.
// ----------------------------------------------------------------------------
package mdiomm_pkg;

	// request opcodes on the op field
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// register map (index taken from the word address)
	localparam int         CFG_ADDR_W      = 3;
	localparam logic       REG_HALF_PERIOD = 1'b0;

	// reset value of the half period register
	localparam logic [11:0] HALF_PERIOD_RESET = 12'd1000;

	// frame constants
	localparam int         PREAMBLE_BITS_DEF = 32;
	localparam int         BIT_W             = 7;
	localparam logic [3:0] SOF_READ          = 4'b0110;
	localparam logic [3:0] SOF_WRITE         = 4'b0101;
	localparam logic [1:0] TA_WRITE          = 2'b10;

	// queue between front and back, power of two depth
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input request as seen on the port
	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  phy_addr;
		logic [4:0]  reg_addr;
		logic [15:0] write_data;
		logic        mdio_in;
	} mdio_req_t;

	// result as seen on the port
	typedef struct packed {
		logic        mdc;
		logic        mdio_out;
		logic        mdio_oe;
		logic        busy_res;
		logic [15:0] read_data;
		logic        read_valid;
		logic        cmd_dropped;
	} mdio_res_t;

	// request class decided by the front end
	typedef enum logic [1:0] {
		CLS_TICK,
		CLS_READ,
		CLS_WRITE
	} req_class_t;

	// classified request held in the queue
	typedef struct packed {
		req_class_t  cls;
		logic [4:0]  phy_addr;
		logic [4:0]  reg_addr;
		logic [15:0] write_data;
		logic        mdio_in;
	} q_entry_t;

endpackage

### rtl/mdiomm_front.sv
// ----------------------------------------------------------------------------
// mdiomm_front
// Accepts requests, classifies the opcode and holds one classified request.
// ----------------------------------------------------------------------------
module mdiomm_front import mdiomm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  mdio_req_t cmd,
	output logic      ent_valid,
	input  logic      ent_ready,
	output q_entry_t  ent
);

	logic       valid_s1;
	q_entry_t   ent_s1;
	req_class_t cls;

	// opcode decode, the unused code acts as a plain tick
	always_comb begin
		unique case (cmd.op)
			OP_READ:  cls = CLS_READ;
			OP_WRITE: cls = CLS_WRITE;
			default:  cls = CLS_TICK;
		endcase
	end

	assign cmd_ready = !valid_s1 || ent_ready;

	// stage register towards the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			ent_s1.cls        <= cls;
			ent_s1.phy_addr   <= cmd.phy_addr;
			ent_s1.reg_addr   <= cmd.reg_addr;
			ent_s1.write_data <= cmd.write_data;
			ent_s1.mdio_in    <= cmd.mdio_in;
		end
	end

	assign ent_valid = valid_s1;
	assign ent       = ent_s1;

endmodule

### rtl/mdiomm_queue.sv
// ----------------------------------------------------------------------------
// mdiomm_queue
// Short fifo of classified requests between the front end and the sequencer.
// ----------------------------------------------------------------------------
module mdiomm_queue import mdiomm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output q_entry_t pop_data
);

	q_entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill level, pointers wrap naturally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/mdiomm_back.sv
// ----------------------------------------------------------------------------
// mdiomm_back
// Pin sequencer: plays one tick of the mdio frame per request and registers
// the result.
// ----------------------------------------------------------------------------
module mdiomm_back import mdiomm_pkg::*; #(
	parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ent_valid,
	output logic        ent_ready,
	input  q_entry_t    ent,
	input  logic [11:0] half_period,
	output logic        res_valid,
	input  logic        res_ready,
	output mdio_res_t   res
);

	localparam int FRAME_W = PREAMBLE_BITS + 32;
	localparam logic [BIT_W-1:0] DRV_READ   = BIT_W'(PREAMBLE_BITS + 14);
	localparam logic [BIT_W-1:0] DRV_WRITE  = BIT_W'(PREAMBLE_BITS + 32);
	localparam logic [BIT_W-1:0] LAST_READ  = BIT_W'(PREAMBLE_BITS + 31);
	localparam logic [BIT_W-1:0] LAST_WRITE = BIT_W'(PREAMBLE_BITS + 32);
	localparam logic [BIT_W-1:0] SAMP_FIRST = BIT_W'(PREAMBLE_BITS + 15);
	localparam logic [BIT_W-1:0] SAMP_LAST  = BIT_W'(PREAMBLE_BITS + 30);

	// sequencer state
	logic               active_q;
	logic [11:0]        tick_q;
	logic [BIT_W-1:0]   bit_q;
	logic               high_q;
	logic [FRAME_W-1:0] shift_q;
	logic [15:0]        in_q;
	logic               is_read_q;
	logic [15:0]        held_q;
	mdio_res_t          res_q;
	logic               res_valid_q;

	// step values
	logic               step;
	logic               is_cmd;
	logic               take;
	logic               run;
	logic [11:0]        cur_tick;
	logic [BIT_W-1:0]   cur_bit;
	logic               cur_high;
	logic [FRAME_W-1:0] cur_shift;
	logic [15:0]        cur_in;
	logic               cur_read;
	logic [31:0]        word;
	logic [11:0]        half_len;
	logic [11:0]        tick_inc;
	logic               driving;
	logic               active_n;
	logic [11:0]        tick_n;
	logic [BIT_W-1:0]   bit_n;
	logic               high_n;
	logic [FRAME_W-1:0] shift_n;
	logic [15:0]        in_n;
	logic [15:0]        held_n;
	logic               rvalid_n;

	assign step      = ent_valid && ent_ready;
	assign ent_ready = !res_valid_q || res_ready;

	// frame start and current view of the state
	always_comb begin
		is_cmd = (ent.cls == CLS_READ) || (ent.cls == CLS_WRITE);
		take   = !active_q && is_cmd;
		run    = active_q || take;
		if (ent.cls == CLS_READ) begin
			word = {SOF_READ, ent.phy_addr, ent.reg_addr, 18'd0};
		end else begin
			word = {SOF_WRITE, ent.phy_addr, ent.reg_addr, TA_WRITE, ent.write_data};
		end
		if (take) begin
			cur_tick  = '0;
			cur_bit   = '0;
			cur_high  = 1'b0;
			cur_shift = {{PREAMBLE_BITS{1'b1}}, word};
			cur_in    = '0;
			cur_read  = ent.cls == CLS_READ;
		end else begin
			cur_tick  = tick_q;
			cur_bit   = bit_q;
			cur_high  = high_q;
			cur_shift = shift_q;
			cur_in    = in_q;
			cur_read  = is_read_q;
		end
	end

	// tick and bit period advance
	always_comb begin
		half_len = (half_period == '0) ? 12'd1 : half_period;
		tick_inc = cur_tick + 12'd1;
		driving  = cur_bit < (cur_read ? DRV_READ : DRV_WRITE);
		active_n = run;
		tick_n   = cur_tick;
		bit_n    = cur_bit;
		high_n   = cur_high;
		shift_n  = cur_shift;
		in_n     = cur_in;
		held_n   = held_q;
		rvalid_n = 1'b0;
		if (run) begin
			tick_n = tick_inc;
			if (tick_inc >= half_len) begin
				tick_n = '0;
				if (!cur_high) begin
					high_n = 1'b1;
				end else begin
					high_n = 1'b0;
					if (cur_read && cur_bit >= SAMP_FIRST && cur_bit <= SAMP_LAST) begin
						in_n = {cur_in[14:0], ent.mdio_in};
					end
					if (driving) begin
						shift_n = {cur_shift[FRAME_W-2:0], 1'b0};
					end
					if (cur_bit >= (cur_read ? LAST_READ : LAST_WRITE)) begin
						active_n = 1'b0;
						if (cur_read) begin
							held_n   = cur_in;
							rvalid_n = 1'b1;
						end
					end else begin
						bit_n = cur_bit + BIT_W'(1);
					end
				end
			end
		end
	end

	// state update, one tick per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			tick_q    <= '0;
			bit_q     <= '0;
			high_q    <= 1'b0;
			shift_q   <= '0;
			in_q      <= '0;
			is_read_q <= 1'b0;
			held_q    <= '0;
		end else if (step) begin
			active_q  <= active_n;
			tick_q    <= tick_n;
			bit_q     <= bit_n;
			high_q    <= high_n;
			shift_q   <= shift_n;
			in_q      <= in_n;
			is_read_q <= cur_read;
			held_q    <= held_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.mdc         <= run && cur_high;
			res_q.mdio_out    <= run && driving && cur_shift[FRAME_W-1];
			res_q.mdio_oe     <= run && driving;
			res_q.busy_res    <= run;
			res_q.read_data   <= held_n;
			res_q.read_valid  <= rvalid_n;
			res_q.cmd_dropped <= active_q && is_cmd;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/mdio_management_master_core.sv
// ----------------------------------------------------------------------------
// mdio_management_master_core
// Clause 22 mdio master: one request per system tick drives the mdc/mdio
// pin sequence, with a front end, a short queue and a pin sequencer.
//
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+-----------------------
// cmd       | in        | cmd_valid / cmd_ready   | mdio_req_t
// res       | out       | res_valid / res_ready   | mdio_res_t
// apb       | in/out    | psel, penable, pready   | half_period_ticks
//
// one request accepted and one result given per cycle when both sides flow
// a request passes the front stage, the queue entry and the result register
// the sequencer updates its state once per request
// reset leaves the sequencer idle and the half period at 1000 ticks
// a stalled result holds the sequencer; the queue absorbs the front end
// ----------------------------------------------------------------------------
module mdio_management_master_core import mdiomm_pkg::*; #(
	parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  mdio_req_t             cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output mdio_res_t             res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic        f_valid;
	logic        f_ready;
	q_entry_t    f_ent;
	logic        q_valid;
	logic        q_ready;
	q_entry_t    q_ent;
	logic [11:0] half_period_q;
	logic        reg_sel;

	// configuration register
	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_ADDR_W-1] == REG_HALF_PERIOD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			half_period_q <= pwdata[11:0];
		end
	end

	assign prdata = reg_sel ? {20'd0, half_period_q} : 32'd0;

	// request front end
	mdiomm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.ent_valid (f_valid),
		.ent_ready (f_ready),
		.ent       (f_ent)
	);

	// decoupling queue
	mdiomm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_ent),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_ent)
	);

	// pin sequencer
	mdiomm_back #(
		.PREAMBLE_BITS (PREAMBLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ent_valid   (q_valid),
		.ent_ready   (q_ready),
		.ent         (q_ent),
		.half_period (half_period_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule
